// File: hdl/rvmd_pkg.sv
// Shared types and constants for the multiply/divide unit.
// No dependencies; every other file of the unit uses this package.
package rvmd_pkg;

   localparam int XLEN_MAX          = 64;
   localparam int CMD_W             = 4;
   localparam int QUEUE_DEPTH_DEF   = 4;
   localparam int DIV_STAGES        = XLEN_MAX;   // one quotient bit per stage
   localparam int MUL_STAGE         = 2;          // chain stage that takes the product

   localparam logic [XLEN_MAX-1:0] MASK_W32 = 64'h0000_0000_FFFF_FFFF;
   localparam logic [XLEN_MAX-1:0] MASK_W64 = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [XLEN_MAX-1:0] SMIN_W32 = 64'h0000_0000_8000_0000;
   localparam logic [XLEN_MAX-1:0] SMIN_W64 = 64'h8000_0000_0000_0000;

   typedef enum logic [CMD_W-1:0] {
      CMD_MUL    = 4'd0,
      CMD_MULH   = 4'd1,
      CMD_MULHSU = 4'd2,
      CMD_MULHU  = 4'd3,
      CMD_DIV    = 4'd4,
      CMD_DIVU   = 4'd5,
      CMD_REM    = 4'd6,
      CMD_REMU   = 4'd7,
      CMD_MULW   = 4'd8,
      CMD_DIVW   = 4'd9,
      CMD_DIVUW  = 4'd10,
      CMD_REMW   = 4'd11,
      CMD_REMUW  = 4'd12
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_FIXED = 2'd0,   // result known at decode (illegal, divide special cases)
      KIND_MUL   = 2'd1,
      KIND_DIV   = 2'd2
   } kind_type;

   // Classified request travelling from the front end to the execution back end.
   typedef struct packed {
      kind_type              kind;
      logic                  want_rem;
      logic                  neg_res;
      logic                  op32;
      logic                  sext;
      logic                  mul_hi;
      logic                  corr_a;
      logic                  corr_b;
      logic                  illegal;
      logic [XLEN_MAX-1:0]   opa;
      logic [XLEN_MAX-1:0]   opb;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef struct packed {
      logic last_valid;
      logic advance;
   } back_stat_type;

endpackage

// File: hdl/rv_muldiv_unit.sv
// Top level of the RISC-V M-extension multiply/divide unit.
// Depends on rvmd_pkg, rvmd_front, rvmd_queue and rvmd_back.

// The unit takes one request per cycle while its queue is not full and returns
// one response per request, in request order. Each request is decoded at the
// front end, parked in a short queue, and run through a fixed-latency back end:
// a multiplier of 32x32 partial products (three stages) beside a 64-stage
// divider chain that resolves one quotient bit per stage. Every request walks
// the whole chain and then the output register, and the whole chain holds while
// a response waits; when nothing stalls, the sustained rate is one request per
// cycle, and the divider chain sets the latency. Division by zero, signed
// overflow and illegal commands are resolved at decode and ride through
// unchanged. The width register may only be written while no request is in flight.
module rv_muldiv_unit #(
   parameter int QUEUE_DEPTH = rvmd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,   // [63:0] operand_first, [127:64] operand_second
   input  logic [3:0]    req_tuser,   // [3:0] command
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [63:0]   rsp_tdata,   // [63:0] result_value
   output logic          rsp_tuser,   // [0] illegal
   input  logic          csr_wr_en,
   input  logic          csr_wr_data  // width_is_64
);

   logic                      width_ff;
   logic                      push, pop;
   rvmd_pkg::item_type        front_item, head_item;
   rvmd_pkg::queue_stat_type  q_stat;
   rvmd_pkg::back_stat_type   b_stat;

   // width register, 64-bit after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 1'b1;
      end else if (csr_wr_en) begin
         width_ff <= csr_wr_data;
      end
   end

   rvmd_front u_front (
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .command        (req_tuser),
      .operand_first  (req_tdata[63:0]),
      .operand_second (req_tdata[127:64]),
      .width_is_64    (width_ff),
      .q_stat         (q_stat),
      .push           (push),
      .item           (front_item)
   );

   rvmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .head_item (head_item),
      .q_stat    (q_stat)
   );

   rvmd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_item    (head_item),
      .head_valid   (!q_stat.empty),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .result_value (rsp_tdata),
      .illegal      (rsp_tuser),
      .b_stat       (b_stat)
   );

   // an illegal response always carries zero data
   a_illegal_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == 64'd0))
      else $error("illegal response with nonzero data");

   // a finished request at the chain end must stay put while output is blocked
   a_chain_hold: assert property (@(posedge clock) disable iff (reset)
      (b_stat.last_valid && !b_stat.advance) |=> b_stat.last_valid)
      else $error("request lost at divider chain end");

   // queue can never be full and empty at once
   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue status inconsistent");

endmodule

// File: hdl/rvmd_front.sv
// Front end of the multiply/divide unit: accepts requests and classifies them.
// Depends on rvmd_pkg.
module rvmd_front (
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rvmd_pkg::CMD_W-1:0]       command,
   input  logic [rvmd_pkg::XLEN_MAX-1:0]    operand_first,
   input  logic [rvmd_pkg::XLEN_MAX-1:0]    operand_second,
   input  logic                             width_is_64,
   input  rvmd_pkg::queue_stat_type         q_stat,
   output logic                             push,
   output rvmd_pkg::item_type               item
);

   logic                            word;
   logic                            op32;
   logic                            is_signed;
   logic                            is_div;
   logic [rvmd_pkg::XLEN_MAX-1:0]   aw;
   logic [rvmd_pkg::XLEN_MAX-1:0]   bw;
   logic [rvmd_pkg::XLEN_MAX-1:0]   mask_val;
   logic [rvmd_pkg::XLEN_MAX-1:0]   smin_val;
   logic                            asgn;
   logic                            bsgn;
   rvmd_pkg::cmd_type               cmd;

   assign req_tready = !q_stat.full;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      cmd       = rvmd_pkg::cmd_type'(command);
      word      = (command >= rvmd_pkg::CMD_MULW) && (command <= rvmd_pkg::CMD_REMUW);
      op32      = !width_is_64 || word;
      mask_val  = op32 ? rvmd_pkg::MASK_W32 : rvmd_pkg::MASK_W64;
      smin_val  = op32 ? rvmd_pkg::SMIN_W32 : rvmd_pkg::SMIN_W64;
      aw        = operand_first & mask_val;
      bw        = operand_second & mask_val;
      asgn      = op32 ? aw[31] : aw[63];
      bsgn      = op32 ? bw[31] : bw[63];
      is_signed = 1'b0;
      is_div    = 1'b0;

      item          = '0;
      item.kind     = rvmd_pkg::KIND_MUL;
      item.op32     = op32;
      item.sext     = word;
      item.opa      = aw;
      item.opb      = bw;

      case (cmd)
         rvmd_pkg::CMD_MUL, rvmd_pkg::CMD_MULW: begin
            item.mul_hi = 1'b0;
         end
         rvmd_pkg::CMD_MULH: begin
            item.mul_hi = 1'b1;
            item.corr_a = asgn;
            item.corr_b = bsgn;
         end
         rvmd_pkg::CMD_MULHSU: begin
            item.mul_hi = 1'b1;
            item.corr_a = asgn;
         end
         rvmd_pkg::CMD_MULHU: begin
            item.mul_hi = 1'b1;
         end
         rvmd_pkg::CMD_DIV, rvmd_pkg::CMD_DIVW: begin
            is_div    = 1'b1;
            is_signed = 1'b1;
         end
         rvmd_pkg::CMD_DIVU, rvmd_pkg::CMD_DIVUW: begin
            is_div    = 1'b1;
         end
         rvmd_pkg::CMD_REM, rvmd_pkg::CMD_REMW: begin
            is_div        = 1'b1;
            is_signed     = 1'b1;
            item.want_rem = 1'b1;
         end
         rvmd_pkg::CMD_REMU, rvmd_pkg::CMD_REMUW: begin
            is_div        = 1'b1;
            item.want_rem = 1'b1;
         end
         default: begin
            item.illegal = 1'b1;
         end
      endcase

      if (is_div) begin
         if (bw == '0) begin
            item.kind = rvmd_pkg::KIND_FIXED;
            item.opa  = item.want_rem ? aw : mask_val;
         end else if (is_signed && (aw == smin_val) && (bw == mask_val)) begin
            item.kind = rvmd_pkg::KIND_FIXED;
            item.opa  = item.want_rem ? '0 : aw;
         end else begin
            item.kind    = rvmd_pkg::KIND_DIV;
            item.opa     = (is_signed && asgn) ? ((~aw + 64'd1) & mask_val) : aw;
            item.opb     = (is_signed && bsgn) ? ((~bw + 64'd1) & mask_val) : bw;
            item.neg_res = is_signed && (item.want_rem ? asgn : (asgn ^ bsgn));
         end
      end

      // word form in 32-bit mode is illegal as well
      if (word && !width_is_64) begin
         item.illegal = 1'b1;
      end
      if (item.illegal) begin
         item      = '0;
         item.kind = rvmd_pkg::KIND_FIXED;
         item.illegal = 1'b1;
      end
   end

endmodule

// File: hdl/rvmd_queue.sv
// Short request queue between front end and back end.
// Depends on rvmd_pkg.
module rvmd_queue #(
   parameter int DEPTH = rvmd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  rvmd_pkg::item_type       push_item,
   input  logic                     pop,
   output rvmd_pkg::item_type       head_item,
   output rvmd_pkg::queue_stat_type q_stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rvmd_pkg::item_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign q_stat.full  = (count_ff == CNT_W'(DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign head_item    = mem_ff[rd_ptr_ff];
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: hdl/rvmd_back.sv
// Execution back end: pipelined multiplier beside a one-bit-per-stage divider
// chain, with the output register. Depends on rvmd_pkg.
module rvmd_back (
   input  logic                                clock,
   input  logic                                reset,
   input  rvmd_pkg::item_type                  head_item,
   input  logic                                head_valid,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rvmd_pkg::XLEN_MAX-1:0]       result_value,
   output logic                                illegal,
   output rvmd_pkg::back_stat_type             b_stat
);

   localparam int N  = rvmd_pkg::DIV_STAGES;
   localparam int XL = rvmd_pkg::XLEN_MAX;

   typedef struct packed {
      logic [XL-1:0] rem;
      logic [XL-1:0] quo;
   } step_type;

   function automatic step_type div_step(input logic [XL-1:0] rem,
                                         input logic [XL-1:0] quo,
                                         input logic [XL-1:0] den);
      logic [XL:0] t;
      logic        ge;
      step_type    s;
      t      = {rem, quo[XL-1]};
      ge     = (t >= {1'b0, den});
      s.rem  = ge ? XL'(t - {1'b0, den}) : t[XL-1:0];
      s.quo  = {quo[XL-2:0], ge};
      return s;
   endfunction

   rvmd_pkg::item_type  st_ff  [N];
   logic [XL-1:0]       rem_ff [N];
   logic                v_ff   [N];

   logic [XL-1:0]       pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff, corr1_ff;
   logic [2*XL-1:0]     prod_ff;
   logic [XL-1:0]       corr2_ff;
   logic [XL-1:0]       mul_val;
   logic [XL-1:0]       mul_hi_part;

   logic                rsp_valid_ff;
   logic [XL-1:0]       rsp_data_ff, rsp_data_in;
   logic                rsp_illegal_ff;
   logic                adv;
   logic [XL-1:0]       raw, signed_val;

   // hold the whole chain while the output register is full and not taken
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign pop        = adv && head_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign result_value = rsp_data_ff;
   assign illegal    = rsp_illegal_ff;
   assign b_stat.last_valid = v_ff[N-1];
   assign b_stat.advance    = adv;

   // multiplier: partial products, then sum, then select beside chain stage 2
   always_ff @(posedge clock) begin
      if (adv) begin
         pp_ll_ff <= head_item.opa[31:0]  * head_item.opb[31:0];
         pp_lh_ff <= head_item.opa[31:0]  * head_item.opb[63:32];
         pp_hl_ff <= head_item.opa[63:32] * head_item.opb[31:0];
         pp_hh_ff <= head_item.opa[63:32] * head_item.opb[63:32];
         corr1_ff <= (head_item.corr_a ? head_item.opb : '0)
                   + (head_item.corr_b ? head_item.opa : '0);
         prod_ff  <= {64'd0, pp_ll_ff} + {32'd0, pp_lh_ff, 32'd0}
                   + {32'd0, pp_hl_ff, 32'd0} + {pp_hh_ff, 64'd0};
         corr2_ff <= corr1_ff;
      end
   end

   assign mul_hi_part = st_ff[rvmd_pkg::MUL_STAGE-1].op32 ? {32'd0, prod_ff[63:32]}
                                                           : prod_ff[127:64];
   assign mul_val = st_ff[rvmd_pkg::MUL_STAGE-1].mul_hi ? (mul_hi_part - corr2_ff)
                                                        : prod_ff[63:0];

   for (genvar k = 0; k < N; k++) begin : g_stage
      rvmd_pkg::item_type src_item;
      rvmd_pkg::item_type st_in;
      logic [XL-1:0]      src_rem;
      logic [XL-1:0]      rem_in;
      logic               src_v;
      step_type           nxt;

      if (k == 0) begin : g_first
         assign src_item = head_item;
         assign src_rem  = '0;
         assign src_v    = head_valid;
      end else begin : g_next
         assign src_item = st_ff[k-1];
         assign src_rem  = rem_ff[k-1];
         assign src_v    = v_ff[k-1];
      end

      assign nxt = div_step(src_rem, src_item.opa, src_item.opb);

      always_comb begin
         st_in  = src_item;
         rem_in = src_rem;
         if (src_item.kind == rvmd_pkg::KIND_DIV) begin
            st_in.opa = nxt.quo;
            rem_in    = nxt.rem;
         end
         if ((k == rvmd_pkg::MUL_STAGE) && (src_item.kind == rvmd_pkg::KIND_MUL)) begin
            st_in.opa = mul_val;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= src_v;
         end
         if (adv) begin
            st_ff[k]  <= st_in;
            rem_ff[k] <= rem_in;
         end
      end
   end

   // format: pick quotient or remainder, apply sign, cut to width, sign-extend words
   always_comb begin
      raw = ((st_ff[N-1].kind == rvmd_pkg::KIND_DIV) && st_ff[N-1].want_rem)
            ? rem_ff[N-1] : st_ff[N-1].opa;
      signed_val = st_ff[N-1].neg_res ? (~raw + 64'd1) : raw;
      if (st_ff[N-1].op32) begin
         rsp_data_in = {(st_ff[N-1].sext ? {32{signed_val[31]}} : 32'd0), signed_val[31:0]};
      end else begin
         rsp_data_in = signed_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v_ff[N-1];
      end
      if (adv) begin
         rsp_data_ff    <= rsp_data_in;
         rsp_illegal_ff <= st_ff[N-1].illegal;
      end
   end

endmodule

// File: verif/rv_muldiv_unit_tb.sv
// Self-checking testbench for the multiply/divide unit: random and directed requests,
// in-order response checking against a behavioural predictor.
// Depends on rvmd_pkg and rv_muldiv_unit.
`timescale 1ns / 100ps

module rv_muldiv_unit_tb;

   typedef struct {
      logic [3:0]  command;
      logic [63:0] opa;
      logic [63:0] opb;
   } muldiv_req_type;

   typedef struct {
      logic [63:0] value;
      logic        illegal;
   } muldiv_rsp_type;

   localparam int LATENCY  = 80;
   localparam int WDOG_MAX = 20000;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [127:0]  req_tdata = '0;   // [63:0] operand_first, [127:64] operand_second
   logic [3:0]    req_tuser = '0;   // [3:0] command
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [63:0]   rsp_tdata;        // [63:0] result_value
   logic          rsp_tuser;        // [0] illegal
   logic          csr_wr_en = 1'b0;
   logic          csr_wr_data = 1'b1;

   muldiv_req_type pending_reqs[$];
   muldiv_rsp_type expected_rsps[$];
   logic        width64 = 1'b1;     // predictor copy of the width register
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_cycles = 0;    // length of the long receiver hold-off
   logic        hold_armed = 1'b0;
   int          recv_hold = 0;      // hold-off cycles left, counted down by its own process
   int          req_accepts = 0;    // requests taken, counted by the monitor
   int          drv_accepts = 0;    // last count the driver acted on
   int          fail_count = 0;
   int          wdog = 0;

   rv_muldiv_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // Divide at a given width with the RISC-V rules for zero divisor and overflow.
   function automatic logic [63:0] div_at_width(logic [63:0] a, logic [63:0] b, logic is64,
                                                logic sgn, logic rem);
      logic [63:0]  mask, smin, q, r;
      logic signed [64:0] sa, sb;
      mask = is64 ? rvmd_pkg::MASK_W64 : rvmd_pkg::MASK_W32;
      smin = is64 ? rvmd_pkg::SMIN_W64 : rvmd_pkg::SMIN_W32;
      a &= mask;
      b &= mask;
      if (b == 0) return rem ? a : mask;
      if (sgn && a == smin && b == mask) return rem ? 64'd0 : a;
      if (!sgn) return rem ? a % b : a / b;
      sa = is64 ? {a[63], a} : {{33{a[31]}}, a[31:0]};
      sb = is64 ? {b[63], b} : {{33{b[31]}}, b[31:0]};
      q = 64'(sa / sb);   // truncates toward zero
      r = 64'(sa % sb);   // takes the sign of the dividend
      return (rem ? r : q) & mask;
   endfunction

   function automatic muldiv_rsp_type predict_muldiv(muldiv_req_type rq, logic w64);
      muldiv_rsp_type rs;
      logic [63:0]  mask, a, b, r;
      logic [127:0] p;
      rvmd_pkg::cmd_type c;
      mask = w64 ? rvmd_pkg::MASK_W64 : rvmd_pkg::MASK_W32;
      a = rq.opa & mask;
      b = rq.opb & mask;
      c = rvmd_pkg::cmd_type'(rq.command);
      r = '0;
      rs.illegal = 1'b0;
      if (rq.command > rvmd_pkg::CMD_REMUW || (rq.command >= rvmd_pkg::CMD_MULW && !w64)) begin
         rs.illegal = 1'b1;
      end else begin
         case (c)
            rvmd_pkg::CMD_MUL: begin
               r = a * b;
            end
            rvmd_pkg::CMD_MULH: begin
               p = w64 ? 128'($signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b}))
                       : 128'($signed({{96{a[31]}}, a[31:0]}) * $signed({{96{b[31]}}, b[31:0]}));
               r = w64 ? p[127:64] : p[63:32];
            end
            rvmd_pkg::CMD_MULHSU: begin
               p = w64 ? 128'($signed({{64{a[63]}}, a}) * $signed({64'd0, b}))
                       : 128'($signed({{96{a[31]}}, a[31:0]}) * $signed({96'd0, b[31:0]}));
               r = w64 ? p[127:64] : p[63:32];
            end
            rvmd_pkg::CMD_MULHU: begin
               p = {64'd0, a} * {64'd0, b};
               r = w64 ? p[127:64] : p[63:32];
            end
            rvmd_pkg::CMD_DIV:   r = div_at_width(a, b, w64, 1'b1, 1'b0);
            rvmd_pkg::CMD_DIVU:  r = div_at_width(a, b, w64, 1'b0, 1'b0);
            rvmd_pkg::CMD_REM:   r = div_at_width(a, b, w64, 1'b1, 1'b1);
            rvmd_pkg::CMD_REMU:  r = div_at_width(a, b, w64, 1'b0, 1'b1);
            rvmd_pkg::CMD_MULW:  r = a * b;
            rvmd_pkg::CMD_DIVW:  r = div_at_width(a, b, 1'b0, 1'b1, 1'b0);
            rvmd_pkg::CMD_DIVUW: r = div_at_width(a, b, 1'b0, 1'b0, 1'b0);
            rvmd_pkg::CMD_REMW:  r = div_at_width(a, b, 1'b0, 1'b1, 1'b1);
            rvmd_pkg::CMD_REMUW: r = div_at_width(a, b, 1'b0, 1'b0, 1'b1);
            default:   r = '0;
         endcase
         // word forms sign-extend their low half
         if (rq.command >= rvmd_pkg::CMD_MULW) r = {{32{r[31]}}, r[31:0]};
      end
      rs.value = r & mask;
      return rs;
   endfunction

   // Driver: offer the head of the pending queue, pausing at random.
   always @(negedge clock) begin
      if (!reset) begin
         // hold an offered request steady until it is taken
         if (!req_tvalid || req_accepts != drv_accepts) begin
            drv_accepts = req_accepts;
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tuser  <= pending_reqs[0].command;
               req_tdata  <= {pending_reqs[0].opb, pending_reqs[0].opa};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         // receiver readiness; hold off entirely during the long stretch
         if (recv_hold > 0) rsp_tready <= 1'b0;
         else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Long receiver hold-off: load once when requested, then count down.
   always @(posedge clock) begin
      if (reset) begin
         recv_hold <= 0;
      end else if (hold_cycles > 0 && !hold_armed) begin
         recv_hold  <= hold_cycles;
         hold_armed <= 1'b1;
      end else if (recv_hold > 0) begin
         recv_hold <= recv_hold - 1;
      end
   end

   // Monitor: record taken requests and compare each response with the oldest expectation.
   always @(posedge clock) begin
      muldiv_rsp_type exp_rsp;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            // request taken at this edge; predict it and drop it
            expected_rsps.push_back(predict_muldiv(pending_reqs[0], width64));
            void'(pending_reqs.pop_front());
            req_accepts++;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) wdog <= 0;
         else wdog <= wdog + 1;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected response value=%h illegal=%b", rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_tdata !== exp_rsp.value) begin
                  $error("result_value expected %h actual %h", exp_rsp.value, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tuser !== exp_rsp.illegal) begin
                  $error("illegal expected %b actual %b", exp_rsp.illegal, rsp_tuser);
                  fail_count++;
               end
            end
         end
         if (wdog >= WDOG_MAX) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   function automatic logic [63:0] pick_operand();
      case ($urandom_range(7))
         0: return 64'd0;
         1: return rvmd_pkg::MASK_W64;
         2: return rvmd_pkg::SMIN_W64;
         3: return rvmd_pkg::SMIN_W32 | ($urandom_range(1) ? 64'hFFFF_FFFF_0000_0000 : 64'd0);
         4: return 64'($urandom_range(9));
         5: return {$urandom(), 32'hFFFF_FFFF};
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   task automatic add_req(logic [3:0] c, logic [63:0] a, logic [63:0] b);
      muldiv_req_type rq;
      rq.command = c;
      rq.opa = a;
      rq.opb = b;
      pending_reqs.push_back(rq);
   endtask

   // Wait for every response, then a margin for anything still in the chain.
   task automatic drain();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_width(logic w);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w;
      width64     = w;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic random_phase(int n);
      logic [3:0] c;
      for (int i = 0; i < n; i++) begin
         // mostly legal commands; the odd unknown one
         c = ($urandom_range(15) == 0) ? 4'($urandom_range(13, 15)) : 4'($urandom_range(12));
         add_req(c, pick_operand(), pick_operand());
      end
   endtask

   initial begin
      int phase_w[4] = '{1, 0, 1, 0};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: every command at the operand extremes, zero divisor, overflow.
      for (int c = 0; c < 16; c++) add_req(4'(c), rvmd_pkg::SMIN_W64, rvmd_pkg::MASK_W64);
      add_req(rvmd_pkg::CMD_DIV, 64'd7, 64'd0);
      add_req(rvmd_pkg::CMD_REM, 64'hFFFF_FFFF_FFFF_FFF9, 64'd0);
      add_req(rvmd_pkg::CMD_DIVW, rvmd_pkg::SMIN_W32, 64'hFFFF_FFFF);
      add_req(rvmd_pkg::CMD_REMW, rvmd_pkg::SMIN_W32, 64'hFFFF_FFFF);
      add_req(rvmd_pkg::CMD_DIVUW, 64'h1234_5678_0000_0010, 64'hFFFF_0000_0000_0000);
      add_req(rvmd_pkg::CMD_MULW, 64'h7FFF_FFFF, 64'd2);
      add_req(rvmd_pkg::CMD_DIV, 64'hFFFF_FFFF_FFFF_FFF9, 64'd2);
      add_req(rvmd_pkg::CMD_MULHSU, rvmd_pkg::MASK_W64, rvmd_pkg::MASK_W64);
      drain();

      // Alternate the width between its two settings while the idling profile changes.
      for (int ph = 0; ph < 4; ph++) begin
         write_width(phase_w[ph][0]);
         if (ph == 0) begin send_idle_pct = 14; recv_idle_pct = 58; end
         else if (ph == 1) begin send_idle_pct = 58; recv_idle_pct = 14; end
         else begin send_idle_pct = 0; recv_idle_pct = 0; end
         if (!width64) begin
            add_req(rvmd_pkg::CMD_MULH, rvmd_pkg::SMIN_W32, rvmd_pkg::MASK_W32);
            add_req(rvmd_pkg::CMD_DIV, rvmd_pkg::SMIN_W32, rvmd_pkg::MASK_W32);
            add_req(rvmd_pkg::CMD_REM, rvmd_pkg::SMIN_W32, rvmd_pkg::MASK_W32);
            add_req(rvmd_pkg::CMD_DIVU, rvmd_pkg::MASK_W64, 64'h1_0000_0000);
         end
         random_phase(180);
         // stall the receiver for a long stretch so the unit backs up
         if (ph == 2) hold_cycles = 300;
         drain();
      end

      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
